// File: hdl/sbb_pkg.sv
`default_nettype none
package sbb_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_RADIUS  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = 16;
    localparam int NUM_CH      = 4;

    localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS = $clog2(RING_ROWS);
    localparam int ADDR_BITS = SLOT_BITS + COL_BITS;
    localparam int RAM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int WORD_BITS = NUM_CH * SAMPLE_BITS;

    localparam int CFG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int EXT_BITS       = 10;
    localparam int RAD_BITS       = 4;
    localparam int WIN_BITS       = $clog2(2 * MAX_RADIUS + 2);
    localparam int N_BITS         = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_BITS       = SAMPLE_BITS + N_BITS;
    localparam int POS_BITS       = EXT_BITS + 3;

    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [OUT_BITS-1:0]    result_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_BLUR_RADIUS   = 2'd2,
        CFG_FOUR_CHANNELS = 2'd3
    } cfg_index_t;

endpackage
`default_nettype wire

// File: hdl/separable_box_blur_top.sv
// Box blur over a (2r+1) x (2r+1) window with edge replication, on 1 or 4
// channels of 16-bit samples in raster order. Received rows live in a ring of
// 2*MAX_RADIUS+2 rows in one line RAM. A word with no result goes from check
// back to idle; one that releases a pixel goes on through accumulate, last,
// start, divide and output, waiting out any output stall. The window is summed
// one RAM read per cycle from the single read port, and the rounded average
// comes from a 25-step divider, one per channel. Drain words (operation 1)
// flush the rows pending at frame end. Configuration writes are taken only
// between words and win over a waiting input word; each one restarts the frame.
`default_nettype none
module separable_box_blur_top import sbb_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_operation,
    input  wire logic [SAMPLE_BITS-1:0]    s_chan0_in,
    input  wire logic [SAMPLE_BITS-1:0]    s_chan1_in,
    input  wire logic [SAMPLE_BITS-1:0]    s_chan2_in,
    input  wire logic [SAMPLE_BITS-1:0]    s_chan3_in,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [OUT_BITS-1:0]            m_chan0_out,
    output logic [OUT_BITS-1:0]            m_chan1_out,
    output logic [OUT_BITS-1:0]            m_chan2_out,
    output logic [OUT_BITS-1:0]            m_chan3_out,
    output logic                           m_frame_end,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]       cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_ACC, ST_LAST, ST_START, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    logic [CFG_BITS-1:0] width_cfg_reg, height_cfg_reg;
    logic [RAD_BITS-1:0] radius_cfg_reg;
    logic                four_reg;

    logic [EXT_BITS-1:0]  icol_reg, irow_reg, ocol_reg, orow_reg;
    logic [SLOT_BITS-1:0] in_slot_reg, out_slot_reg, rd_slot_reg;
    logic [WIN_BITS-1:0]  dx_reg, dy_reg;
    logic signed [POS_BITS-1:0] yv_reg;
    logic [EXT_BITS-1:0]  ycl_reg;
    logic                 rd_valid_reg;
    logic                 last_reg;
    sum_t                 sum_reg [NUM_CH];

    logic [EXT_BITS-1:0] w, h;
    logic [RAD_BITS-1:0] r;
    logic [N_BITS-1:0]   n;
    logic [WIN_BITS-1:0] win_last;

    logic s_accept, cfg_accept, push;
    logic [ADDR_BITS-1:0] rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data, rd_data;
    logic [EXT_BITS-1:0]  need_row, need_col, xcl, ycl_init, ycl_step;
    logic [SLOT_BITS-1:0] slot_init;
    logic signed [POS_BITS-1:0] xv, yv_init, yv_step;
    logic out_ready;

    sum_t    dividend [NUM_CH];
    result_t quotient [NUM_CH];
    logic    div_done;

    function automatic logic [EXT_BITS-1:0] clamp_pos(
        input logic signed [POS_BITS-1:0] v,
        input logic [EXT_BITS-1:0] lim
    );
        logic [EXT_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v >= $signed({3'b000, lim})) begin
            res = lim - 1'b1;
        end else begin
            res = v[EXT_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] res;
        if (s == SLOT_BITS'(RING_ROWS - 1)) begin
            res = '0;
        end else begin
            res = s + 1'b1;
        end
        return res;
    endfunction

    // effective extents and radius
    always_comb begin
        logic [RAD_BITS-1:0] rr;
        logic [WIN_BITS-1:0] win;
        if (width_cfg_reg == '0) begin
            w = EXT_BITS'(1);
        end else if (width_cfg_reg > CFG_BITS'(MAX_WIDTH)) begin
            w = EXT_BITS'(MAX_WIDTH);
        end else begin
            w = width_cfg_reg;
        end
        if (height_cfg_reg == '0) begin
            h = EXT_BITS'(1);
        end else if (height_cfg_reg > CFG_BITS'(MAX_HEIGHT)) begin
            h = EXT_BITS'(MAX_HEIGHT);
        end else begin
            h = height_cfg_reg;
        end
        rr = radius_cfg_reg;
        if (rr > RAD_BITS'(MAX_RADIUS)) rr = RAD_BITS'(MAX_RADIUS);
        if ({6'd0, rr} > (w >> 1)) rr = RAD_BITS'(w >> 1);
        if ({6'd0, rr} > (h >> 1)) rr = RAD_BITS'(h >> 1);
        r        = rr;
        win      = {rr, 1'b1};
        win_last = {rr, 1'b0};
        n        = N_BITS'(win) * N_BITS'(win);
    end

    assign s_ready    = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign push = s_accept && !s_operation && (irow_reg < h) && (icol_reg < w) &&
                  ({1'b0, irow_reg} + {7'd0, r} <
                   {1'b0, orow_reg} + (EXT_BITS + 1)'(RING_ROWS));

    assign wr_addr = {in_slot_reg, icol_reg[COL_BITS-1:0]};
    assign wr_data = {four_reg ? s_chan3_in : '0, four_reg ? s_chan2_in : '0,
                      four_reg ? s_chan1_in : '0, s_chan0_in};

    always_comb begin
        need_row = ({1'b0, orow_reg} + {7'd0, r} > {1'b0, h - 1'b1}) ? h - 1'b1
                                                                      : orow_reg + r;
        need_col = ({1'b0, ocol_reg} + {7'd0, r} > {1'b0, w - 1'b1}) ? w - 1'b1
                                                                      : ocol_reg + r;
        out_ready = (orow_reg < h) && (ocol_reg < w) &&
                    ((irow_reg > need_row) ||
                     (irow_reg == need_row && icol_reg > need_col));

        yv_init  = $signed({3'b000, orow_reg}) - $signed({9'd0, r});
        ycl_init = clamp_pos(yv_init, h);
        if (yv_init < 0) begin
            slot_init = '0;
        end else if (out_slot_reg >= SLOT_BITS'(r)) begin
            slot_init = out_slot_reg - SLOT_BITS'(r);
        end else begin
            slot_init = SLOT_BITS'(out_slot_reg + SLOT_BITS'(RING_ROWS) - SLOT_BITS'(r));
        end
        yv_step  = yv_reg + 2'sb01;
        ycl_step = clamp_pos(yv_step, h);

        xv  = $signed({3'b000, ocol_reg}) - $signed({9'd0, r}) +
              $signed({8'd0, dx_reg});
        xcl = clamp_pos(xv, w);
        rd_addr = {rd_slot_reg, xcl[COL_BITS-1:0]};

        for (int c = 0; c < NUM_CH; c++) begin
            dividend[c] = sum_reg[c] + SUM_BITS'(n >> 1);
        end
    end

    sbb_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .dividend (dividend),
        .divisor  (n),
        .done     (div_done),
        .quotient (quotient)
    );

    // window sums: accumulate every returned word
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            for (int c = 0; c < NUM_CH; c++) sum_reg[c] <= '0;
        end else if (rd_valid_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= sum_reg[c] +
                              SUM_BITS'(rd_data[c*SAMPLE_BITS +: SAMPLE_BITS]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= CFG_BITS'(512);
            height_cfg_reg <= CFG_BITS'(512);
            radius_cfg_reg <= RAD_BITS'(1);
            four_reg       <= 1'b1;
            icol_reg       <= '0;
            irow_reg       <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            in_slot_reg    <= '0;
            out_slot_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_ACC);
            if (m_valid && m_ready && state_reg != ST_OUT) m_valid <= 1'b0;

            if (push) begin
                if (icol_reg + 1'b1 >= w) begin
                    icol_reg    <= '0;
                    irow_reg    <= irow_reg + 1'b1;
                    in_slot_reg <= slot_inc(in_slot_reg);
                end else begin
                    icol_reg <= icol_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    dx_reg      <= '0;
                    dy_reg      <= '0;
                    yv_reg      <= yv_init;
                    ycl_reg     <= ycl_init;
                    rd_slot_reg <= slot_init;
                    last_reg    <= (orow_reg == h - 1'b1) && (ocol_reg == w - 1'b1);
                    state_reg   <= out_ready ? ST_ACC : ST_IDLE;
                end
                ST_ACC: begin
                    if (dx_reg == win_last) begin
                        dx_reg  <= '0;
                        dy_reg  <= dy_reg + 1'b1;
                        yv_reg  <= yv_step;
                        ycl_reg <= ycl_step;
                        if (ycl_step != ycl_reg) rd_slot_reg <= slot_inc(rd_slot_reg);
                        if (dy_reg == win_last) state_reg <= ST_LAST;
                    end else begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                end
                ST_LAST: begin
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid     <= 1'b1;
                        m_chan0_out <= quotient[0];
                        m_chan1_out <= four_reg ? quotient[1] : '0;
                        m_chan2_out <= four_reg ? quotient[2] : '0;
                        m_chan3_out <= four_reg ? quotient[3] : '0;
                        m_frame_end <= last_reg;
                        state_reg   <= ST_IDLE;
                        if (last_reg) begin
                            icol_reg     <= '0;
                            irow_reg     <= '0;
                            ocol_reg     <= '0;
                            orow_reg     <= '0;
                            in_slot_reg  <= '0;
                            out_slot_reg <= '0;
                        end else if (ocol_reg + 1'b1 >= w) begin
                            ocol_reg     <= '0;
                            orow_reg     <= orow_reg + 1'b1;
                            out_slot_reg <= slot_inc(out_slot_reg);
                        end else begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // register write restarts the frame
            if (cfg_accept) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:   width_cfg_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT:  height_cfg_reg <= cfg_data;
                    CFG_BLUR_RADIUS:   radius_cfg_reg <= cfg_data[RAD_BITS-1:0];
                    CFG_FOUR_CHANNELS: four_reg       <= cfg_data[0];
                    default: ;
                endcase
                icol_reg     <= '0;
                irow_reg     <= '0;
                ocol_reg     <= '0;
                orow_reg     <= '0;
                in_slot_reg  <= '0;
                out_slot_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/sbb_ram.sv
`default_nettype none
module sbb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: hdl/sbb_div.sv
`default_nettype none
module sbb_div import sbb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire sum_t              dividend [NUM_CH],
    input  wire logic [N_BITS-1:0] divisor,
    output logic                   done,
    output result_t                quotient [NUM_CH]
);
    localparam int CNT_BITS = $clog2(SUM_BITS);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [N_BITS-1:0]   dvs_reg;
    sum_t                dvd_reg [NUM_CH];
    logic [N_BITS-1:0]   rem_reg [NUM_CH];
    logic [N_BITS:0]     shifted [NUM_CH];
    logic                fits    [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            shifted[c] = {rem_reg[c], dvd_reg[c][SUM_BITS-1]};
            fits[c]    = shifted[c] >= {1'b0, dvs_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // restoring division, quotient bits shift in behind the dividend
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            for (int c = 0; c < NUM_CH; c++) begin
                dvd_reg[c] <= dividend[c];
                rem_reg[c] <= '0;
            end
        end else if (busy_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                dvd_reg[c] <= {dvd_reg[c][SUM_BITS-2:0], fits[c]};
                rem_reg[c] <= fits[c] ? N_BITS'(shifted[c] - {1'b0, dvs_reg})
                                      : shifted[c][N_BITS-1:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            quotient[c] = dvd_reg[c][OUT_BITS-1:0];
        end
    end
endmodule
`default_nettype wire
